// ----- rtl/sst_pkg.sv -----
// sst_pkg: word types, action and status codes, controller-to-datapath command
// and status structs for the sparse set table
// no dependencies
package sst_pkg;

	localparam int KEY_W     = 10;
	localparam int POS_W     = 10;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 10;
	localparam int COUNT_W   = 11;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd4;

	// dense read address select
	localparam logic [1:0] DA_POS  = 2'd0;
	localparam logic [1:0] DA_LAST = 2'd1;
	localparam logic [1:0] DA_HIT  = 2'd2;

	// result source
	localparam logic [1:0] RK_EVAL   = 2'd0;
	localparam logic [1:0] RK_REMOVE = 2'd1;
	localparam logic [1:0] RK_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] payload;
		logic [POS_W-1:0]  position;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                present;
		logic [SLOT_W-1:0]   slot;
		logic [KEY_W-1:0]    key_out;
		logic [DATA_W-1:0]   payload_out;
		logic [COUNT_W-1:0]  count;
	} rsp_word_t;

	typedef struct packed {
		logic       clr_wr;
		logic       cap;
		logic       rd_map;
		logic       rd_dense;
		logic [1:0] dense_sel;
		logic       ins_wr;
		logic       mv_wr;
		logic       inv_wr;
		logic       res_ld;
		logic [1:0] res_kind;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       clr_done;
		logic       ins_ok;
		logic       rm_ok;
		logic       look_hit;
		logic       out_free;
	} stat_t;

endpackage

// ----- rtl/sst_dp.sv -----
// sst_dp: datapath of the sparse set table, with key map, dense key and payload
// memories, entry count, clear counter and response register
// depends on sst_pkg
module sst_dp import sst_pkg::*; #(
	parameter int KEY_SPACE     = 1024,
	parameter int CAPACITY      = 1024,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output stat_t     st,
	input  req_word_t req_word,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output rsp_word_t rsp_word
);

	localparam int MAP_AW = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
	localparam int DAW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int PW     = PAYLOAD_WIDTH;

	logic [DAW:0]       map_mem [KEY_SPACE];
	logic [KEY_W-1:0]   dkey_mem [CAPACITY];
	logic [PW-1:0]      dpay_mem [CAPACITY];

	req_word_t          req_q;
	logic [CW-1:0]      count_q;
	logic [MAP_AW-1:0]  clr_cnt_q;
	logic [DAW:0]       map_rd_q;
	logic [KEY_W-1:0]   dkey_rd_q;
	logic [PW-1:0]      dpay_rd_q;
	rsp_word_t          rsp_q;
	logic               rsp_valid_q;

	logic               in_space;
	logic               has;
	logic [DAW-1:0]     hit_pos;
	logic               hit_lt_cnt;
	logic               full;
	logic [CW-1:0]      last_cnt;
	logic               pos_ok;

	logic               map_we;
	logic [MAP_AW-1:0]  map_wa;
	logic [DAW:0]       map_wd;
	logic [MAP_AW-1:0]  map_ra;
	logic               dense_we;
	logic [DAW-1:0]     dense_wa;
	logic [KEY_W-1:0]   dkey_wd;
	logic [PW-1:0]      dpay_wd;
	logic [DAW-1:0]     dense_ra;
	rsp_word_t          rsp_d;

	assign in_space   = 32'(req_q.key) < 32'(KEY_SPACE);
	assign has        = in_space && map_rd_q[DAW];
	assign hit_pos    = map_rd_q[DAW-1:0];
	assign hit_lt_cnt = CW'(hit_pos) < count_q;
	assign full       = count_q == CW'(CAPACITY);
	assign last_cnt   = count_q - CW'(1);
	assign pos_ok     = 32'(req_q.position) < 32'(count_q);

	assign st.action   = req_q.action;
	assign st.clr_done = clr_cnt_q == MAP_AW'(KEY_SPACE - 1);
	assign st.ins_ok   = in_space && !has && !full;
	assign st.rm_ok    = has && hit_lt_cnt && (count_q != '0);
	assign st.look_hit = has && hit_lt_cnt;
	assign st.out_free = !rsp_valid_q || !rsp_stall;

	// memory port muxing
	assign map_ra = MAP_AW'(req_q.key);

	always_comb begin
		map_we = 1'b1;
		map_wa = MAP_AW'(req_q.key);
		map_wd = '0;
		if (cmd.clr_wr) begin
			map_wa = clr_cnt_q;
		end else if (cmd.ins_wr) begin
			map_wd = {1'b1, count_q[DAW-1:0]};
		end else if (cmd.mv_wr) begin
			map_wa = MAP_AW'(dkey_rd_q);
			map_wd = {1'b1, hit_pos};
		end else if (!cmd.inv_wr) begin
			map_we = 1'b0;
		end
	end

	always_comb begin
		dense_we = cmd.ins_wr || cmd.mv_wr;
		if (cmd.ins_wr) begin
			dense_wa = count_q[DAW-1:0];
			dkey_wd  = req_q.key;
			dpay_wd  = PW'(req_q.payload);
		end else begin
			dense_wa = hit_pos;
			dkey_wd  = dkey_rd_q;
			dpay_wd  = dpay_rd_q;
		end
	end

	always_comb begin
		case (cmd.dense_sel)
			DA_POS:  dense_ra = DAW'(req_q.position);
			DA_LAST: dense_ra = last_cnt[DAW-1:0];
			default: dense_ra = hit_pos;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (cmd.rd_map) begin
			map_rd_q <= map_mem[map_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (dense_we) begin
			dkey_mem[dense_wa] <= dkey_wd;
			dpay_mem[dense_wa] <= dpay_wd;
		end
		if (cmd.rd_dense) begin
			dkey_rd_q <= dkey_mem[dense_ra];
			dpay_rd_q <= dpay_mem[dense_ra];
		end
	end

	// response word
	always_comb begin
		rsp_d         = '0;
		rsp_d.status  = ST_OK;
		rsp_d.count   = COUNT_W'(count_q);
		case (cmd.res_kind)
			RK_REMOVE: begin
				rsp_d.present = 1'b1;
				rsp_d.slot    = SLOT_W'(hit_pos);
				rsp_d.count   = COUNT_W'(last_cnt);
			end
			RK_LOOKUP: begin
				rsp_d.present     = 1'b1;
				rsp_d.slot        = SLOT_W'(hit_pos);
				rsp_d.key_out     = req_q.key;
				rsp_d.payload_out = DATA_W'(dpay_rd_q);
			end
			default: begin
				case (req_q.action)
					ACT_INSERT: begin
						if (!in_space) begin
							rsp_d.status = ST_RANGE;
						end else if (has) begin
							rsp_d.status  = ST_DUP;
							rsp_d.present = 1'b1;
							rsp_d.slot    = SLOT_W'(hit_pos);
						end else if (full) begin
							rsp_d.status = ST_FULL;
						end else begin
							rsp_d.slot  = SLOT_W'(count_q);
							rsp_d.count = COUNT_W'(count_q + CW'(1));
						end
					end
					ACT_REMOVE: begin
						rsp_d.status = ST_ABSENT;
					end
					ACT_LOOKUP: begin
						rsp_d.status = ST_OK;
					end
					default: begin
						if (pos_ok) begin
							rsp_d.present     = 1'b1;
							rsp_d.slot        = SLOT_W'(req_q.position);
							rsp_d.key_out     = dkey_rd_q;
							rsp_d.payload_out = DATA_W'(dpay_rd_q);
						end else begin
							rsp_d.status = ST_RANGE;
						end
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req_word;
		end
		if (cmd.res_ld) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
			end
			if (cmd.ins_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.inv_wr) begin
				count_q <= last_cnt;
			end
			if (cmd.res_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

// ----- rtl/sst_ctrl.sv -----
// sst_ctrl: controller state machine of the sparse set table, sequencing
// the map clear pass and the memory steps of each action
// depends on sst_pkg
module sst_ctrl import sst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MAP  = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_MOVE = 3'd4;
	localparam logic [2:0] S_INV  = 3'd5;
	localparam logic [2:0] S_LOOK = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = S_MAP;
				end
			end
			S_MAP: begin
				cmd.rd_map    = 1'b1;
				cmd.rd_dense  = 1'b1;
				cmd.dense_sel = DA_POS;
				state_d       = S_EVAL;
			end
			S_EVAL: begin
				cmd.res_kind = RK_EVAL;
				if (st.action == ACT_REMOVE && st.rm_ok) begin
					cmd.rd_dense  = 1'b1;
					cmd.dense_sel = DA_LAST;
					state_d       = S_MOVE;
				end else if (st.action == ACT_LOOKUP && st.look_hit) begin
					cmd.rd_dense  = 1'b1;
					cmd.dense_sel = DA_HIT;
					state_d       = S_LOOK;
				end else if (st.out_free) begin
					cmd.res_ld = 1'b1;
					cmd.ins_wr = (st.action == ACT_INSERT) && st.ins_ok;
					state_d    = S_IDLE;
				end
			end
			S_MOVE: begin
				cmd.mv_wr = 1'b1;
				state_d   = S_INV;
			end
			S_INV: begin
				cmd.res_kind = RK_REMOVE;
				if (st.out_free) begin
					cmd.inv_wr = 1'b1;
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_LOOK: begin
				cmd.res_kind = RK_LOOKUP;
				if (st.out_free) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/sparse_set_table.sv -----
// sparse_set_table: sparse set of keys with one payload word per entry.
// After reset the key map is swept invalid, one entry a cycle, over all keys,
// during which req_stall stays high. Then one word is handled at a time: the
// key map and dense memories are read with registered reads, then the
// response is loaded, a lookup hit first reading the payload at the hit slot
// and a remove first moving the last entry into the freed slot. The response
// register lets a new word be accepted while the last response still waits.
// Depends on sst_pkg, sst_ctrl and sst_dp.
module sparse_set_table import sst_pkg::*; #(
	parameter int KEY_SPACE     = 1024,
	parameter int CAPACITY      = 1024,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word
);

	cmd_t  cmd;
	stat_t st;

	sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	sst_dp #(
		.KEY_SPACE     (KEY_SPACE),
		.CAPACITY      (CAPACITY),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_word  (req_word),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_word  (rsp_word)
	);

	a_clr_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> req_stall)
		else $error("map clear while requests accepted");

	a_res_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> st.out_free)
		else $error("response loaded over a pending response");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while one is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_word.count) <= 32'(CAPACITY))
		else $error("entry count beyond capacity");

endmodule

// ----- bench/sparse_set_table_tb.sv -----
// sparse_set_table_tb: self-checking bench for the sparse set table, with an
// in-bench model of the key map and dense arrays, random idling on both sides
// depends on sst_pkg and sparse_set_table
module sparse_set_table_tb;
	import sst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 1024;
	localparam int KEYS = 1024;
	localparam int FILL_KEYS = 96;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 80;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_word_t req_word;
	logic rsp_valid;
	logic rsp_stall;
	rsp_word_t rsp_word;

	// model of the table
	bit in_set[KEYS];
	bit [KEY_W-1:0] key_slot[KEYS];
	bit [KEY_W-1:0] slot_key[SLOTS];
	bit [DATA_W-1:0] slot_payload[SLOTS];
	int n_entries;
	int peak_entries;

	rsp_word_t due_rsp[$];
	int fails;
	int words_sent;
	int rsp_checked;
	int sent_by_action[4];
	int quiet_cycles;
	bit idle_on;
	bit hold_rsp;

	sparse_set_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word(req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word(rsp_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic rsp_word_t set_apply(req_word_t w);
		rsp_word_t r;
		bit has;
		bit [KEY_W-1:0] at;
		bit [KEY_W-1:0] moved;
		r = '0;
		has = in_set[w.key];
		at = key_slot[w.key];
		case (w.action)
			ACT_INSERT: begin
				if (has) begin
					r.status = ST_DUP;
					r.present = 1'b1;
					r.slot = at;
				end else if (n_entries >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					at = KEY_W'(n_entries);
					in_set[w.key] = 1'b1;
					key_slot[w.key] = at;
					slot_key[at] = w.key;
					slot_payload[at] = w.payload;
					n_entries++;
					r.status = ST_OK;
					r.slot = at;
				end
			end
			ACT_REMOVE: begin
				if (!has) begin
					r.status = ST_ABSENT;
				end else begin
					moved = slot_key[KEY_W'(n_entries - 1)];
					key_slot[moved] = at;
					slot_key[at] = moved;
					slot_payload[at] = slot_payload[KEY_W'(n_entries - 1)];
					in_set[w.key] = 1'b0;
					n_entries--;
					r.status = ST_OK;
					r.present = 1'b1;
					r.slot = at;
				end
			end
			ACT_LOOKUP: begin
				r.status = ST_OK;
				if (has) begin
					r.present = 1'b1;
					r.slot = at;
					r.key_out = w.key;
					r.payload_out = slot_payload[at];
				end
			end
			default: begin
				if (w.position < n_entries) begin
					r.status = ST_OK;
					r.present = 1'b1;
					r.slot = w.position;
					r.key_out = slot_key[w.position];
					r.payload_out = slot_payload[w.position];
				end else begin
					r.status = ST_RANGE;
				end
			end
		endcase
		r.count = COUNT_W'(n_entries);
		if (n_entries > peak_entries)
			peak_entries = n_entries;
		return r;
	endfunction

	function automatic req_word_t mk(logic [1:0] act, int key, logic [DATA_W-1:0] data,
		int pos);
		req_word_t w;
		w.action = act;
		w.key = KEY_W'(key);
		w.payload = data;
		w.position = POS_W'(pos);
		return w;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input req_word_t w);
		int gap;
		req_word <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		due_rsp.push_back(set_apply(w));
		words_sent++;
		sent_by_action[w.action]++;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic stop_sending();
		req_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		while (due_rsp.size() != 0) @(negedge clk);
	endtask

	function automatic int some_present_key();
		if (n_entries == 0)
			return $urandom_range(0, KEYS - 1);
		return int'(slot_key[KEY_W'($urandom_range(0, n_entries - 1))]);
	endfunction

	function automatic req_word_t random_word();
		req_word_t w;
		int pick;
		w = mk(ACT_LOOKUP, $urandom_range(0, KEYS - 1), $urandom(), $urandom_range(0, SLOTS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			w.action = ACT_INSERT;
			if ($urandom_range(0, 3) == 0)
				w.key = KEY_W'(some_present_key());
		end else if (pick < 60) begin
			w.action = ACT_REMOVE;
			if ($urandom_range(0, 9) < 7)
				w.key = KEY_W'(some_present_key());
		end else if (pick < 80) begin
			w.action = ACT_LOOKUP;
			if ($urandom_range(0, 9) < 6)
				w.key = KEY_W'(some_present_key());
		end else begin
			w.action = ACT_READ;
			if ($urandom_range(0, 4) != 0)
				w.position = POS_W'($urandom_range(0, n_entries + 1));
		end
		return w;
	endfunction

	task automatic test_directed();
		send_word(mk(ACT_LOOKUP, 0, $urandom(), 0));
		send_word(mk(ACT_READ, 0, $urandom(), 0));
		send_word(mk(ACT_REMOVE, 1023, $urandom(), 1023));
		send_word(mk(ACT_INSERT, 0, 32'h0000_0000, 0));
		send_word(mk(ACT_INSERT, 1023, 32'hFFFF_FFFF, 1023));
		send_word(mk(ACT_INSERT, 10'h155, 32'hAAAA_AAAA, 10'h2AA));
		send_word(mk(ACT_INSERT, 1023, 32'h1234_5678, 0));
		send_word(mk(ACT_LOOKUP, 1023, 32'hFFFF_FFFF, 1023));
		send_word(mk(ACT_LOOKUP, 10'h2AA, 0, 0));
		send_word(mk(ACT_READ, 0, 0, 0));
		send_word(mk(ACT_READ, 0, 0, 1));
		send_word(mk(ACT_READ, 0, 0, 2));
		send_word(mk(ACT_READ, 0, 0, 3));
		send_word(mk(ACT_READ, 1023, 32'hFFFF_FFFF, 1023));
		// remove the first entry, the last one moves into its slot
		send_word(mk(ACT_REMOVE, 0, 0, 0));
		send_word(mk(ACT_LOOKUP, 10'h155, 0, 0));
		send_word(mk(ACT_READ, 0, 0, 0));
		// remove the entry that moved into the first slot, then the same key again
		send_word(mk(ACT_REMOVE, 10'h155, 0, 0));
		send_word(mk(ACT_REMOVE, 10'h155, 0, 0));
		send_word(mk(ACT_INSERT, 10'h2AA, 32'h5555_5555, 10'h155));
		send_word(mk(ACT_READ, 0, 0, 10'h155));
		send_word(mk(ACT_LOOKUP, 1023, 0, 0));
		send_word(mk(ACT_LOOKUP, 10'h2AA, 0, 0));
	endtask

	task automatic test_fill_and_drain();
		int off;
		int k;
		off = $urandom_range(0, KEYS - 1);
		for (int i = 0; i < FILL_KEYS; i++) begin
			k = (i + off) % KEYS;
			if (!in_set[KEY_W'(k)])
				send_word(mk(ACT_INSERT, k, $urandom(), $urandom_range(0, SLOTS - 1)));
		end
		send_word(mk(ACT_READ, 0, 0, SLOTS - 1));
		send_word(mk(ACT_INSERT, $urandom_range(0, KEYS - 1), $urandom(), 0));
		send_word(mk(ACT_LOOKUP, some_present_key(), 0, 0));
		while (n_entries > 0) begin
			send_word(mk(ACT_REMOVE, some_present_key(), $urandom(), $urandom_range(0, 1023)));
			if ($urandom_range(0, 15) == 0)
				send_word(mk(ACT_READ, 0, 0, $urandom_range(0, n_entries)));
		end
		send_word(mk(ACT_READ, 0, 0, 0));
	endtask

	task automatic test_backpressure();
		hold_rsp = 1'b1;
		repeat (12) send_word(random_word());
		stop_sending();
		wait_drain();
	endtask

	task automatic test_pause();
		repeat (10) send_word(random_word());
		stop_sending();
		wait_drain();
		repeat (10) send_word(random_word());
	endtask

	task automatic test_random(input int n_words);
		repeat (n_words) send_word(random_word());
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsp.size() == 0) begin
				$error("response word with none outstanding: %p", rsp_word);
				fails++;
			end else begin
				want = due_rsp.pop_front();
				check_field("status", DATA_W'(want.status), DATA_W'(rsp_word.status));
				check_field("present", DATA_W'(want.present), DATA_W'(rsp_word.present));
				check_field("slot", DATA_W'(want.slot), DATA_W'(rsp_word.slot));
				check_field("key_out", DATA_W'(want.key_out), DATA_W'(rsp_word.key_out));
				check_field("payload_out", want.payload_out, rsp_word.payload_out);
				check_field("count", DATA_W'(want.count), DATA_W'(rsp_word.count));
				rsp_checked++;
			end
		end
	end

	always begin
		int n;
		@(negedge clk);
		if (hold_rsp) begin
			rsp_stall <= 1'b1;
			repeat (LONG_HOLD) @(negedge clk);
			hold_rsp = 1'b0;
			rsp_stall <= 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 7);
			rsp_stall <= 1'b1;
			repeat (n) @(negedge clk);
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles with no word moving", quiet_cycles);
			$display("sparse_set_table_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_word = '0;
		rsp_stall = 1'b0;
		idle_on = 1'b1;
		hold_rsp = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_fill_and_drain();
		test_backpressure();
		test_pause();
		test_random(280);
		idle_on = 1'b0;
		test_random(60);
		stop_sending();
		wait_drain();
		repeat (20) @(posedge clk);

		$display("covered %0d words: %0d insert, %0d remove, %0d lookup, %0d read-at",
			words_sent, sent_by_action[ACT_INSERT], sent_by_action[ACT_REMOVE],
			sent_by_action[ACT_LOOKUP], sent_by_action[ACT_READ]);
		$display("checked %0d responses, table peaked at %0d entries, %0d mismatches",
			rsp_checked, peak_entries, fails);
		if (fails == 0 && due_rsp.size() == 0)
			$display("sparse_set_table_tb passed");
		else
			$display("sparse_set_table_tb failed");
		$finish;
	end
endmodule

// ----- sparse_set_table.f -----
rtl/sst_pkg.sv
rtl/sst_dp.sv
rtl/sst_ctrl.sv
rtl/sparse_set_table.sv
bench/sparse_set_table_tb.sv
